// ----- src/scl_pkg.sv -----
package scl_pkg;

  localparam int CELLS_PER_AXIS = 64;
  localparam int MAX_ITEMS      = 65536;
  localparam int COORD_BITS     = 24;

  localparam int NUM_AXES    = 3;
  localparam int AXIS_BITS   = $clog2(CELLS_PER_AXIS);
  localparam int NUM_CELLS   = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
  localparam int CELL_BITS   = $clog2(NUM_CELLS);
  localparam int ITEM_BITS   = $clog2(MAX_ITEMS);
  localparam int HEAD_BITS   = 17;
  localparam int RECIP_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_BITS   = COORD_BITS + RECIP_BITS;
  localparam int QUOT_BITS   = PROD_BITS - FRAC_BITS;
  localparam int DATA_BITS   = 32;
  localparam int INDEX_BITS  = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [HEAD_BITS-1:0] EMPTY_HEAD = '1;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_CPU_X     = 3'd3,
    REG_CPU_Y     = 3'd4,
    REG_CPU_Z     = 3'd5
  } scl_reg_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_BITS-1:0] box_min;
    logic [NUM_AXES-1:0][RECIP_BITS-1:0] recip;
  } scl_cfg_t;

  typedef struct packed {
    logic [ITEM_BITS-1:0] item;
    logic [CELL_BITS-1:0] cell_id;
  } scl_entry_t;

endpackage

// ----- src/scl_front.sv -----
module scl_front
  import scl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  scl_cfg_t              cfg,
  input  logic                  clearing,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ITEM_BITS-1:0]  item_index,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [COORD_BITS-1:0] pos_z,
  output logic                  push_valid,
  input  logic                  push_ready,
  output scl_entry_t            push_entry
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_PUSH} state_t;

  state_t                              state;
  logic [ITEM_BITS-1:0]                item;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] diff;
  logic [NUM_AXES-1:0]                 below;
  logic [NUM_AXES-1:0][PROD_BITS-1:0]  prod;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] pos;
  logic [NUM_AXES-1:0][AXIS_BITS-1:0]  grid;
  logic [QUOT_BITS-1:0]                quot;

  assign pos = {pos_z, pos_y, pos_x};

  assign in_ready   = (state == S_IDLE) && !clearing;
  assign push_valid = (state == S_PUSH);

  // floor of the scaled offset, clamped into the grid
  always_comb begin
    quot = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      quot = prod[a][PROD_BITS-1:FRAC_BITS];
      if (below[a]) begin
        grid[a] = '0;
      end else if (quot >= QUOT_BITS'(CELLS_PER_AXIS)) begin
        grid[a] = AXIS_BITS'(CELLS_PER_AXIS - 1);
      end else begin
        grid[a] = quot[AXIS_BITS-1:0];
      end
    end
  end

  assign push_entry.item = item;
  assign push_entry.cell_id =
    (CELL_BITS'(grid[0]) * CELL_BITS'(CELLS_PER_AXIS) + CELL_BITS'(grid[1]))
    * CELL_BITS'(CELLS_PER_AXIS) + CELL_BITS'(grid[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= item_index;
            for (int a = 0; a < NUM_AXES; a++) begin
              diff[a]  <= pos[a] - cfg.box_min[a];
              below[a] <= pos[a] < cfg.box_min[a];
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            prod[a] <= PROD_BITS'(diff[a]) * PROD_BITS'(cfg.recip[a]);
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("front takes an item while busy");
  a_push_after_mul: assert property (@(posedge clk) disable iff (rst)
    $rose(push_valid) |-> $past(state == S_MUL))
    else $error("push without a product step");
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("input taken during clearing pass");
`endif

endmodule

// ----- src/scl_queue.sv -----
module scl_queue
  import scl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  scl_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop_ready,
  output scl_entry_t pop_entry
);

  localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  scl_entry_t            slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  push;
  logic                  pop;

  assign push_ready = (count != COUNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != COUNT_BITS'(QUEUE_DEPTH) && count != '0) |->
      (PTR_BITS'(wr_ptr - rd_ptr) == PTR_BITS'(count)))
    else $error("queue pointers disagree with count");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointer gap");
`endif

endmodule

// ----- src/scl_back.sv -----
module scl_back
  import scl_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  output logic                        clearing,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  scl_entry_t                  pop_entry,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic        [CELL_BITS-1:0] cell_index,
  output logic signed [HEAD_BITS-1:0] prior_head
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_WRITE} state_t;

  state_t               state;
  logic [CELL_BITS-1:0] clr_addr;
  logic [ITEM_BITS-1:0] cur_item;
  logic [CELL_BITS-1:0] cur_cell;

  logic [HEAD_BITS-1:0] heads [NUM_CELLS];
  logic [HEAD_BITS-1:0] links [MAX_ITEMS];
  logic [HEAD_BITS-1:0] head_rdata;
  logic                 head_we;
  logic [CELL_BITS-1:0] head_waddr;
  logic [HEAD_BITS-1:0] head_wdata;
  logic                 pop;

  assign clearing  = (state == S_CLEAR);
  assign pop_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    head_we    = 1'b0;
    head_waddr = cur_cell;
    head_wdata = HEAD_BITS'(cur_item);
    if (state == S_CLEAR) begin
      head_we    = 1'b1;
      head_waddr = clr_addr;
      head_wdata = EMPTY_HEAD;
    end else if (state == S_WRITE) begin
      head_we = 1'b1;
    end
  end

  // head memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (head_we) begin
      heads[head_waddr] <= head_wdata;
    end
    head_rdata <= heads[pop_entry.cell_id];
  end

  // link memory: old head goes into the particle's entry
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      links[cur_item] <= head_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CELL_BITS'(NUM_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur_item <= pop_entry.item;
            cur_cell <= pop_entry.cell_id;
            state    <= S_WRITE;
          end
        end
        S_WRITE: begin
          cell_index <= cur_cell;
          prior_head <= head_rdata;
          out_valid  <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> !out_valid)
    else $error("result register overwritten");
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop_ready)
    else $error("queue popped during clearing pass");
  a_write_follows_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_WRITE))
    else $error("pop not followed by head update");
`endif

endmodule

// ----- src/spatial_cell_list_build_unit.sv -----
// Cell linked list builder for 3-D neighbor search.
// Input channel (in_valid/in_ready): one particle per transfer, item_index
// and pos_x/pos_y/pos_z. Each axis is binned as
// floor((pos - box_min) * cells_per_unit), clamped into the grid, and the
// three bins form a flat cell_index, x major. The cell's head becomes the
// particle's link, the particle becomes the new head.
// Output channel (out_valid/out_ready): one transfer per particle, in order,
// with cell_index and prior_head (-1 when the cell was empty).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write registers only while the block is idle.
// Path: offset and product registers in the front, the queue, then the
// back's head read and result register. The front sequencer takes one
// particle at a time (offset, multiply, bin) until the bin is pushed; the
// back read-modify-write of the head memory keeps up and hides behind it.
// Reset: registers clear, then a clearing pass writes every one of the
// 262144 head entries to empty, one per cycle; in_ready stays low for it.
// Receiver stall: the result register holds, the back stops popping, the
// 4-entry queue fills, and the front then holds in_ready low.
module spatial_cell_list_build_unit
  import scl_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic        [ITEM_BITS-1:0]  item_index,
  input  logic        [COORD_BITS-1:0] pos_x,
  input  logic        [COORD_BITS-1:0] pos_y,
  input  logic        [COORD_BITS-1:0] pos_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [CELL_BITS-1:0]  cell_index,
  output logic signed [HEAD_BITS-1:0]  prior_head,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [INDEX_BITS-1:0] cfg_index,
  input  logic        [DATA_BITS-1:0]  cfg_data
);

  scl_cfg_t   cfg;
  logic       clearing;
  logic       push_valid;
  logic       push_ready;
  scl_entry_t push_entry;
  logic       pop_valid;
  logic       pop_ready;
  scl_entry_t pop_entry;

  // config writes never stall
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (scl_reg_t'(cfg_index))
        REG_BOX_MIN_X: cfg.box_min[0] <= cfg_data[COORD_BITS-1:0];
        REG_BOX_MIN_Y: cfg.box_min[1] <= cfg_data[COORD_BITS-1:0];
        REG_BOX_MIN_Z: cfg.box_min[2] <= cfg_data[COORD_BITS-1:0];
        REG_CPU_X:     cfg.recip[0]   <= cfg_data[RECIP_BITS-1:0];
        REG_CPU_Y:     cfg.recip[1]   <= cfg_data[RECIP_BITS-1:0];
        REG_CPU_Z:     cfg.recip[2]   <= cfg_data[RECIP_BITS-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // front: accept and bin
  scl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clearing   (clearing),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_index (item_index),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // short queue decouples binning from the head memory
  scl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // back: head memory update, link write, result register
  scl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .clearing   (clearing),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_index (cell_index),
    .prior_head (prior_head)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cell_index)
      && $stable(prior_head)))
    else $error("result dropped while stalled");
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !in_ready))
    else $error("block active right after reset");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import scl_pkg::*;

  localparam int NUM_REGS        = 6;
  localparam int NUM_INDEXES     = 2 ** INDEX_BITS;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 104;
  localparam int HOT_SPOTS       = 6;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  typedef struct {
    logic [CELL_BITS-1:0] cell_id;
    logic [HEAD_BITS-1:0] head;
  } binned_t;

  typedef struct packed {
    logic [ITEM_BITS-1:0]  item;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } particle_t;

  // Mirror of the head store plus the binning registers; every accepted
  // particle pushes the cell it lands in and the head it displaces.
  class cell_list_scoreboard;
    logic [HEAD_BITS-1:0]  heads [NUM_CELLS];
    logic [COORD_BITS-1:0] box_min [NUM_AXES];
    logic [RECIP_BITS-1:0] recip [NUM_AXES];
    binned_t               pending_bins [$];
    int                    errors;

    function new();
      foreach (heads[i]) heads[i] = EMPTY_HEAD;
      foreach (box_min[a]) begin
        box_min[a] = '0;
        recip[a]   = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [INDEX_BITS-1:0] idx, logic [DATA_BITS-1:0] data);
      case (idx)
        REG_BOX_MIN_X: box_min[0] = data[COORD_BITS-1:0];
        REG_BOX_MIN_Y: box_min[1] = data[COORD_BITS-1:0];
        REG_BOX_MIN_Z: box_min[2] = data[COORD_BITS-1:0];
        REG_CPU_X:     recip[0]   = data;
        REG_CPU_Y:     recip[1]   = data;
        REG_CPU_Z:     recip[2]   = data;
        default: ;
      endcase
    endfunction

    function logic [AXIS_BITS-1:0] bin_axis(logic [COORD_BITS-1:0] pos, int axis);
      logic [63:0] scaled;
      if (pos < box_min[axis]) return '0;
      scaled = (64'(pos) - 64'(box_min[axis])) * 64'(recip[axis]);
      scaled = scaled >> FRAC_BITS;
      if (scaled >= CELLS_PER_AXIS) return AXIS_BITS'(CELLS_PER_AXIS - 1);
      return scaled[AXIS_BITS-1:0];
    endfunction

    function void note_particle(particle_t p);
      binned_t b;
      b.cell_id = {bin_axis(p.x, 0), bin_axis(p.y, 1), bin_axis(p.z, 2)};
      b.head = heads[b.cell_id];
      heads[b.cell_id] = HEAD_BITS'(p.item);
      pending_bins.push_back(b);
    endfunction

    function void check_result(logic [CELL_BITS-1:0] cell_id, logic [HEAD_BITS-1:0] head);
      binned_t b;
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual cell_index %0h prior_head %0d",
                 $time, cell_id, $signed(head));
        errors++;
        return;
      end
      b = pending_bins.pop_front();
      if (cell_id !== b.cell_id) begin
        $display("%0t: cell_index mismatch: expected %0h, actual %0h", $time, b.cell_id,
                 cell_id);
        errors++;
      end
      if (head !== b.head) begin
        $display("%0t: prior_head mismatch: expected %0d, actual %0d",
                 $time, $signed(b.head), $signed(head));
        errors++;
      end
    endfunction

    function int pending();
      return pending_bins.size();
    endfunction
  endclass

  logic                         clk        = 1'b0;
  logic                         rst        = 1'b1;
  logic                         in_valid   = 1'b0;
  logic                         in_ready;
  logic        [ITEM_BITS-1:0]  item_index = '0;
  logic        [COORD_BITS-1:0] pos_x      = '0;
  logic        [COORD_BITS-1:0] pos_y      = '0;
  logic        [COORD_BITS-1:0] pos_z      = '0;
  logic                         out_valid;
  logic                         out_ready  = 1'b0;
  logic        [CELL_BITS-1:0]  cell_index;
  logic signed [HEAD_BITS-1:0]  prior_head;
  logic                         cfg_valid  = 1'b0;
  logic                         cfg_ready;
  logic        [INDEX_BITS-1:0] cfg_index  = '0;
  logic        [DATA_BITS-1:0]  cfg_data   = '0;

  cell_list_scoreboard sb;

  // Set while neither side inserts gaps or stalls: back-to-back traffic.
  bit steady = 1'b1;

  // Region of the current grid that random particles aim at, per axis.
  logic [COORD_BITS-1:0] grid_base [NUM_AXES];
  int unsigned           grid_span [NUM_AXES];

  int unsigned cycles = 0;

  spatial_cell_list_build_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_index (item_index),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_index (cell_index),
    .prior_head (prior_head),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: covers the head clearing pass after reset plus every particle
  // with its worst gap, stall and pipeline time, several times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic particle_t make_particle(logic [ITEM_BITS-1:0] item,
                                              logic [COORD_BITS-1:0] x,
                                              logic [COORD_BITS-1:0] y,
                                              logic [COORD_BITS-1:0] z);
    particle_t p;
    p.item = item;
    p.x    = x;
    p.y    = y;
    p.z    = z;
    return p;
  endfunction

  // Draw a particle inside (or just past the top of) the programmed grid.
  function automatic particle_t grid_particle();
    logic [COORD_BITS-1:0] c [NUM_AXES];
    foreach (c[a]) c[a] = grid_base[a] + COORD_BITS'($urandom_range(0, grid_span[a]));
    return make_particle(ITEM_BITS'($urandom), c[0], c[1], c[2]);
  endfunction

  // Present one particle and hold it until the transfer. Valid is lowered
  // only for a gap, so back-to-back particles never see a low/high pair
  // in one time step.
  task automatic send_particle(particle_t p);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    item_index <= p.item;
    pos_x      <= p.x;
    pos_y      <= p.y;
    pos_z      <= p.z;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_particle(p);
  endtask

  // Drop valid and wait until every result is back, then let the pipeline
  // settle before anything touches the registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every index in turn, the unused ones too; valid stays high
  // across the burst and drops once at the end.
  task automatic program_regs(logic [DATA_BITS-1:0] vals [NUM_INDEXES]);
    for (int i = 0; i < NUM_INDEXES; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= INDEX_BITS'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_reg(INDEX_BITS'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: stall a random number of cycles per result, then take
  // and check whatever transfers.
  initial begin
    int unsigned stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(cell_index, prior_head);
    end
  end

  initial begin
    logic [DATA_BITS-1:0] vals [NUM_INDEXES];
    particle_t            hot [HOT_SPOTS];
    particle_t            p;
    longint unsigned      reach;
    int unsigned          pick;

    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Registers still at reset: zero reciprocals put everything in cell 0,
    // so the second particle must see the first as prior head.
    send_particle(make_particle(16'h0000, 24'h000000, 24'h000000, 24'h000000));
    send_particle(make_particle(16'hFFFF, COORD_MAX, COORD_MAX, COORD_MAX));
    wait_idle();

    // Directed grid: x in 256-unit cells from 0x100000, y with the largest
    // reciprocal (anything above the minimum clamps high), z with a zero
    // reciprocal.
    vals[REG_BOX_MIN_X] = 32'h0010_0000;
    vals[REG_BOX_MIN_Y] = 32'h0000_0000;
    vals[REG_BOX_MIN_Z] = 32'h0080_0000;
    vals[REG_CPU_X]     = 32'h0000_0100;
    vals[REG_CPU_Y]     = 32'hFFFF_FFFF;
    vals[REG_CPU_Z]     = 32'h0000_0000;
    for (int i = NUM_REGS; i < NUM_INDEXES; i++) vals[i] = $urandom;
    program_regs(vals);

    // At the box minimum: joins cell 0 behind the two earlier particles.
    send_particle(make_particle(16'h0001, 24'h100000, 24'h000000, 24'h800000));
    // Below the minimum on x and z, one unit above on y.
    send_particle(make_particle(16'h0002, 24'h0FFFFF, 24'h000001, 24'h7FFFFF));
    // Exactly the last x cell, top coordinates on y and z.
    send_particle(make_particle(16'h0003, 24'h103F00, COORD_MAX, COORD_MAX));
    // One cell past the grid on x.
    send_particle(make_particle(16'h0004, 24'h104000, 24'h800000, 24'h000000));
    send_particle(make_particle(16'h0005, COORD_MAX, COORD_MAX, COORD_MAX));
    // Both sides of the first x cell boundary.
    send_particle(make_particle(16'h0006, 24'h1000FF, 24'h000000, 24'h000000));
    send_particle(make_particle(16'h0007, 24'h100100, 24'h000000, 24'h000000));
    // Reused indexes into an occupied cell, back to back.
    send_particle(make_particle(16'hFFFF, 24'h100000, 24'h000000, 24'h800000));
    send_particle(make_particle(16'h0001, 24'h100000, 24'h000000, 24'h800000));
    // Back-to-back inserts into one cell: the second must see the first as prior head.
    send_particle(make_particle(16'h8000, 24'h103F00, COORD_MAX, COORD_MAX));
    send_particle(make_particle(16'h8001, 24'h103F00, COORD_MAX, COORD_MAX));
    send_particle(make_particle(16'h7FFF, 24'h000000, 24'h000000, 24'h000000));
    send_particle(make_particle(16'h5555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA));
    send_particle(make_particle(16'hAAAA, 24'h555555, 24'hAAAAAA, 24'h555555));
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        case (ph)
          // Zero minimum, largest reciprocal: only the two extreme cells.
          0: begin
            vals[REG_BOX_MIN_X + a] = '0;
            vals[REG_CPU_X + a]     = '1;
          end
          // All-ones minimum (upper bits dropped): everything piles into cell 0.
          1: begin
            vals[REG_BOX_MIN_X + a] = '1;
            vals[REG_CPU_X + a]     = $urandom_range(32'h100, 32'h4_0000);
          end
          // Zero reciprocal on z only.
          2: begin
            vals[REG_BOX_MIN_X + a] = $urandom_range(0, 32'h80_0000);
            vals[REG_CPU_X + a]     = (a == NUM_AXES - 1) ? '0
                                      : $urandom_range(32'h100, 32'h4_0000);
          end
          // Raw random words on every register.
          3: begin
            vals[REG_BOX_MIN_X + a] = $urandom;
            vals[REG_CPU_X + a]     = $urandom;
          end
          default: begin
            vals[REG_BOX_MIN_X + a] = $urandom_range(0, 32'h80_0000);
            vals[REG_CPU_X + a]     = $urandom_range(32'h100, 32'h4_0000);
          end
        endcase
        // Aim random particles at the grid: 64 cells span 64 * 2^16 / recip units.
        grid_base[a] = vals[REG_BOX_MIN_X + a][COORD_BITS-1:0];
        if (vals[REG_CPU_X + a] == 0) begin
          reach = 64'(COORD_MAX);
        end else begin
          reach = ((longint'(CELLS_PER_AXIS) << FRAC_BITS) / vals[REG_CPU_X + a]) + 1;
          if (reach > COORD_MAX) reach = 64'(COORD_MAX);
        end
        grid_span[a] = 32'(reach);
      end
      for (int i = NUM_REGS; i < NUM_INDEXES; i++) vals[i] = $urandom;
      program_regs(vals);

      // A few phases run with no gaps or stalls at all.
      steady = (ph == 2 || ph == 5);

      // A handful of hot spots per phase builds long chains in a few cells.
      foreach (hot[h]) hot[h] = grid_particle();

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          p      = hot[$urandom_range(0, HOT_SPOTS - 1)];
          p.item = ITEM_BITS'($urandom);
        end else if (pick < 8) begin
          p = grid_particle();
        end else begin
          p = make_particle(ITEM_BITS'($urandom), COORD_BITS'($urandom),
                            COORD_BITS'($urandom), COORD_BITS'($urandom));
        end
        send_particle(p);
      end
      // Hold off until every result is back before reprogramming.
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
